@@ sv/double_ended_queue_defines.svh @@
// -----------------------------------------------------------------------------
// double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue modules.
// -----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deq_pkg
// Types, codes and defaults shared by the double-ended queue modules.
// -----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEQ_DEPTH = 16;
	localparam int DATA_W    = 32;

	// request codes
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_LIST       = 3'd4;

	// result status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] value;
	} deq_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item_value;
		logic                     last_of_run;
	} deq_rsp_t;

	typedef enum logic [1:0] {
		DEQ_IDLE,
		DEQ_EXEC,
		DEQ_LOAD,
		DEQ_EMIT
	} deq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_F,
		OP_PUSH_B,
		OP_POP_F,
		OP_POP_B,
		OP_LIST_RD
	} deq_op_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ECHO,
		RES_FULL,
		RES_EMPTY,
		RES_RAM
	} deq_res_t;

	typedef struct packed {
		logic       take;
		deq_op_t    op;
		deq_res_t   res;
		logic       res_last;
		logic       idx_inc;
	} deq_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       empty;
		logic       full;
		logic       list_last;
		logic       res_last;
	} deq_sts_t;

endpackage

@@ sv/double_ended_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// -----------------------------------------------------------------------------
// Holds up to DEPTH signed values. Each item on req asks to push at the front
// or back, pop from the front or back, or list the contents front to back.
// Pushes and pops give one result each; a push into a full queue comes back
// with status full and the offered value echoed, a pop or listing of an empty
// queue comes back with status empty and value zero. A listing gives one
// result per stored entry, last_of_run set on the final one. Request codes 5
// to 7 are dropped without a result. One item is worked at a time: the
// sequencer returns to accept the next item only after the final result of
// the current one is taken, or at once for an unused code. A result is held
// while rsp_ready is low. A push or an empty result is registered as the
// item executes; a popped or listed entry is first read from the entry
// store, a RAM with a single registered read port, read once per popped or
// listed entry, and is then registered in the load state. The store needs
// no clearing after reset.
// -----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_rsp_t rsp
);

	// command and status between sequencer and datapath
	deq_pkg::deq_cmd_t cmd;
	deq_pkg::deq_sts_t sts;

	// sequencer: accept, execute, read the store, hold the result
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: front index, entry count, entry store and result register
	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ sv/deq_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/deq_datapath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deq_datapath
// Ring pointers, entry store and result register of the double-ended queue.
// -----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_datapath #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  deq_pkg::deq_req_t req,
	input  deq_pkg::deq_cmd_t cmd,
	output deq_pkg::deq_sts_t sts,
	output deq_pkg::deq_rsp_t rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);

	logic [2:0]                        req_type_q;
	logic signed [deq_pkg::DATA_W-1:0] val_q;
	logic [IDX_W-1:0]                  front_q;
	logic [CNT_W-1:0]                  count_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [1:0]                        res_status_q;
	logic signed [deq_pkg::DATA_W-1:0] res_value_q;
	logic                              res_last_q;

	logic [IDX_W-1:0]           front_dec;
	logic [IDX_W-1:0]           front_inc;
	logic [IDX_W-1:0]           back_slot;
	logic [IDX_W-1:0]           tail_slot;
	logic [IDX_W-1:0]           list_slot;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic                       ram_re;
	logic [IDX_W-1:0]           ram_raddr;
	logic [deq_pkg::DATA_W-1:0] ram_rdata;

	// slot arithmetic modulo DEPTH; both operands stay below DEPTH
	function automatic logic [IDX_W-1:0] slot_add(
		input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b
	);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	always_comb begin
		front_dec = (front_q == '0) ? LAST_SLOT : front_q - IDX_W'(1);
		front_inc = (front_q == LAST_SLOT) ? '0 : front_q + IDX_W'(1);
		back_slot = slot_add(front_q, count_q[IDX_W-1:0]);
		tail_slot = slot_add(front_q, count_q[IDX_W-1:0] - IDX_W'(1));
		list_slot = slot_add(front_q, idx_q);

		ram_we    = (cmd.op == deq_pkg::OP_PUSH_F) || (cmd.op == deq_pkg::OP_PUSH_B);
		ram_waddr = (cmd.op == deq_pkg::OP_PUSH_F) ? front_dec : back_slot;
		ram_re    = (cmd.op == deq_pkg::OP_POP_F) || (cmd.op == deq_pkg::OP_POP_B) ||
			(cmd.op == deq_pkg::OP_LIST_RD);
		case (cmd.op)
			deq_pkg::OP_POP_F: ram_raddr = front_q;
			deq_pkg::OP_POP_B: ram_raddr = tail_slot;
			default:           ram_raddr = list_slot;
		endcase
	end

	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (val_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (cmd.op)
				deq_pkg::OP_PUSH_F: begin
					front_q <= front_dec;
					count_q <= count_q + ONE_C;
				end
				deq_pkg::OP_PUSH_B: count_q <= count_q + ONE_C;
				deq_pkg::OP_POP_F: begin
					front_q <= front_inc;
					count_q <= count_q - ONE_C;
				end
				deq_pkg::OP_POP_B: count_q <= count_q - ONE_C;
				default: ;
			endcase
			if (cmd.take) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_type_q <= req.req_type;
			val_q      <= req.value;
		end
		case (cmd.res)
			deq_pkg::RES_ECHO: begin
				res_status_q <= deq_pkg::STS_DONE;
				res_value_q  <= val_q;
			end
			deq_pkg::RES_FULL: begin
				res_status_q <= deq_pkg::STS_FULL;
				res_value_q  <= val_q;
			end
			deq_pkg::RES_EMPTY: begin
				res_status_q <= deq_pkg::STS_EMPTY;
				res_value_q  <= '0;
			end
			deq_pkg::RES_RAM: begin
				res_status_q <= deq_pkg::STS_DONE;
				res_value_q  <= ram_rdata;
			end
			default: ;
		endcase
		if (cmd.res != deq_pkg::RES_NONE) begin
			res_last_q <= cmd.res_last;
		end
	end

	always_comb begin
		sts.req_type  = req_type_q;
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == DEPTH_C);
		sts.list_last = ((CNT_W'(idx_q) + ONE_C) == count_q);
		sts.res_last  = res_last_q;
		rsp.status      = res_status_q;
		rsp.item_value  = res_value_q;
		rsp.last_of_run = res_last_q;
	end

	`DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "entry count above depth")
	`DEQ_ASSERT_NEXT(a_push_grows, ram_we, count_q == $past(count_q) + ONE_C, "push lost count")
	`DEQ_ASSERT_NOW(a_push_not_full, ram_we, count_q != DEPTH_C, "write into a full queue")
	`DEQ_ASSERT_NOW(a_pop_not_empty, ram_re, count_q != '0, "read from an empty queue")

endmodule

@@ sv/deq_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer of the double-ended queue.
// -----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  deq_pkg::deq_sts_t sts,
	output deq_pkg::deq_cmd_t cmd
);

	deq_pkg::deq_state_t state_q;
	deq_pkg::deq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::DEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		rsp_valid    = 1'b0;
		cmd.take     = 1'b0;
		cmd.op       = deq_pkg::OP_NONE;
		cmd.res      = deq_pkg::RES_NONE;
		cmd.res_last = 1'b1;
		cmd.idx_inc  = 1'b0;
		unique case (state_q)
			deq_pkg::DEQ_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = deq_pkg::DEQ_EXEC;
				end
			end
			deq_pkg::DEQ_EXEC: begin
				unique case (sts.req_type) inside
					deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
						if (sts.full) begin
							cmd.res = deq_pkg::RES_FULL;
						end else begin
							cmd.op  = (sts.req_type == deq_pkg::REQ_PUSH_FRONT) ?
								deq_pkg::OP_PUSH_F : deq_pkg::OP_PUSH_B;
							cmd.res = deq_pkg::RES_ECHO;
						end
						state_d = deq_pkg::DEQ_EMIT;
					end
					deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
						if (sts.empty) begin
							cmd.res = deq_pkg::RES_EMPTY;
							state_d = deq_pkg::DEQ_EMIT;
						end else begin
							cmd.op  = (sts.req_type == deq_pkg::REQ_POP_FRONT) ?
								deq_pkg::OP_POP_F : deq_pkg::OP_POP_B;
							state_d = deq_pkg::DEQ_LOAD;
						end
					end
					deq_pkg::REQ_LIST: begin
						if (sts.empty) begin
							cmd.res = deq_pkg::RES_EMPTY;
							state_d = deq_pkg::DEQ_EMIT;
						end else begin
							cmd.op  = deq_pkg::OP_LIST_RD;
							state_d = deq_pkg::DEQ_LOAD;
						end
					end
					default: state_d = deq_pkg::DEQ_IDLE;
				endcase
			end
			deq_pkg::DEQ_LOAD: begin
				cmd.res      = deq_pkg::RES_RAM;
				cmd.res_last = (sts.req_type == deq_pkg::REQ_LIST) ? sts.list_last : 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = deq_pkg::DEQ_EMIT;
			end
			deq_pkg::DEQ_EMIT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = sts.res_last ? deq_pkg::DEQ_IDLE : deq_pkg::DEQ_EXEC;
				end
			end
			default: state_d = deq_pkg::DEQ_IDLE;
		endcase
	end

	`DEQ_ASSERT_NEXT(a_take_exec, req_valid && req_ready, state_q == deq_pkg::DEQ_EXEC, "accepted item not executed")
	`DEQ_ASSERT_NOW(a_more_is_list, rsp_valid && !sts.res_last, sts.req_type == deq_pkg::REQ_LIST, "non-final result outside a listing")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded double-ended queue.
// -----------------------------------------------------------------------------
// A driver process presents request items from a pending list, in bursts with
// random gaps. A second process drives rsp_ready on changing patterns and
// holds it low once for a long stretch, so the queue stalls its input. A
// monitor process checks every accepted result against a software copy of the
// queue, updated as each request is accepted. The stimulus starts with a
// directed set and continues with runs that fill, drain or mix.
// -----------------------------------------------------------------------------
module testbench;

	import deq_pkg::*;

	localparam int DEPTH           = DEQ_DEPTH;
	localparam int RANDOM_ITEMS    = 260;
	localparam int HOLD_OFF_AT     = 40;
	localparam int HOLD_OFF_CYCLES = 400;
	// long enough for a full listing, leave margin on top
	localparam int DRAIN_CYCLES    = 4 * DEPTH + 16;
	localparam int CYCLE_LIMIT     = 400000;

	localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum int {
		GEN_FILL,
		GEN_DRAIN,
		GEN_MIX
	} gen_mode_t;

	typedef enum int {
		RCV_ALWAYS,
		RCV_COIN,
		RCV_PERIODIC
	} rcv_pattern_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	deq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	deq_rsp_t rsp;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -------------------------------------------------------------------------
	// Shadow copy of the queue and the results it still owes
	// -------------------------------------------------------------------------
	logic signed [DATA_W-1:0] shadow_store [DEPTH];
	int                       shadow_front = 0;
	int                       shadow_count = 0;
	deq_rsp_t                 expected_rsps [$];

	deq_req_t pending_reqs [$];
	int       total_items    = 0;

	int accepted_cnt   = 0;
	int checked_cnt    = 0;
	int ignored_cnt    = 0;
	int refused_cnt    = 0;
	int empty_cnt      = 0;
	int full_lists     = 0;
	int fail_cnt       = 0;
	int cycle_cnt      = 0;

	// Work out the results one request causes and advance the shadow queue.
	task automatic predict_results(input deq_req_t r);
		deq_rsp_t e;
		int       slot;
		int       i;
		e             = '0;
		e.last_of_run = 1'b1;
		case (r.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				// a push always echoes the offered value, refused or not
				e.item_value = r.value;
				if (shadow_count == DEPTH) begin
					e.status = STS_FULL;
					refused_cnt++;
				end else begin
					if (r.req_type == REQ_PUSH_FRONT) begin
						shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
						slot         = shadow_front;
					end else begin
						slot = (shadow_front + shadow_count) % DEPTH;
					end
					shadow_store[slot] = r.value;
					shadow_count++;
					e.status = STS_DONE;
				end
				expected_rsps.push_back(e);
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (shadow_count == 0) begin
					e.status = STS_EMPTY;
					empty_cnt++;
				end else begin
					if (r.req_type == REQ_POP_FRONT) begin
						slot         = shadow_front;
						shadow_front = (shadow_front + 1) % DEPTH;
					end else begin
						slot = (shadow_front + shadow_count - 1) % DEPTH;
					end
					shadow_count--;
					e.status     = STS_DONE;
					e.item_value = shadow_store[slot];
				end
				expected_rsps.push_back(e);
			end
			REQ_LIST: begin
				if (shadow_count == 0) begin
					e.status = STS_EMPTY;
					empty_cnt++;
					expected_rsps.push_back(e);
				end else begin
					if (shadow_count == DEPTH)
						full_lists++;
					// one result per entry, front to back, last one marked
					for (i = 0; i < shadow_count; i++) begin
						e.status      = STS_DONE;
						e.item_value  = shadow_store[(shadow_front + i) % DEPTH];
						e.last_of_run = (i == shadow_count - 1);
						expected_rsps.push_back(e);
					end
				end
			end
			default: begin
				// unused codes are dropped with no result
				ignored_cnt++;
			end
		endcase
	endtask

	task automatic check_rsp(input deq_rsp_t want, input deq_rsp_t got);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_cnt++;
		end
		if (got.item_value !== want.item_value) begin
			$error("item_value: expected %0d, got %0d", want.item_value, got.item_value);
			fail_cnt++;
		end
		if (got.last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0b, got %0b", want.last_of_run,
				got.last_of_run);
			fail_cnt++;
		end
	endtask

	// -------------------------------------------------------------------------
	// Stimulus helpers
	// -------------------------------------------------------------------------
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			2: return DATA_W'($urandom_range(0, 15));
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Append one item to the pending list.
	function automatic void queue_req(input logic [2:0] code,
		input logic signed [DATA_W-1:0] v);
		deq_req_t r;
		r.req_type = code;
		r.value    = v;
		pending_reqs.push_back(r);
		total_items++;
	endfunction

	function automatic logic [2:0] rand_push();
		return ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
	endfunction

	function automatic logic [2:0] rand_pop();
		return ($urandom_range(0, 1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK;
	endfunction

	// -------------------------------------------------------------------------
	// Driver: offer pending items in bursts, hold each until it is taken
	// -------------------------------------------------------------------------
	int       drv_burst_left = 0;
	int       drv_gap_left   = 0;
	logic     drv_offer;
	deq_req_t drv_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid      <= 1'b0;
			req            <= '0;
			drv_burst_left  = 0;
			drv_gap_left    = 0;
		end else if (!req_valid || req_ready) begin
			drv_offer = 1'b0;
			drv_next  = req;
			if (drv_gap_left > 0) begin
				drv_gap_left--;
			end else if (pending_reqs.size() > 0) begin
				if (drv_burst_left == 0)
					drv_burst_left = $urandom_range(1, 20);
				drv_next  = pending_reqs.pop_front();
				drv_offer = 1'b1;
				drv_burst_left--;
				// about half the bursts run straight into the next one
				if (drv_burst_left == 0)
					drv_gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
			end
			req_valid <= drv_offer;
			req       <= drv_next;
		end
	end

	// -------------------------------------------------------------------------
	// Receiver: switch between stall patterns, hold off once for a long stretch
	// -------------------------------------------------------------------------
	rcv_pattern_t rcv_pattern   = RCV_ALWAYS;
	int           rcv_left      = 0;
	int           rcv_hold_left = 0;
	bit           rcv_hold_done = 1'b0;
	logic         rcv_take;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (!rcv_hold_done && accepted_cnt >= HOLD_OFF_AT) begin
				rcv_hold_done = 1'b1;
				rcv_hold_left = HOLD_OFF_CYCLES;
			end
			if (rcv_left == 0) begin
				rcv_pattern = rcv_pattern_t'($urandom_range(0, 2));
				rcv_left    = $urandom_range(20, 120);
			end
			rcv_left--;
			if (rcv_hold_left > 0) begin
				rcv_hold_left--;
				rcv_take = 1'b0;
			end else begin
				case (rcv_pattern)
					RCV_ALWAYS: rcv_take = 1'b1;
					RCV_COIN:   rcv_take = ($urandom_range(0, 1) != 0);
					default:    rcv_take = ((rcv_left % 5) >= 2);
				endcase
			end
			rsp_ready <= rcv_take;
		end
	end

	// -------------------------------------------------------------------------
	// Monitor: check results first, then predict from the accepted request.
	// A result can never belong to a request taken at the same edge.
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result with none expected: status %0d item_value %0d last %0b",
						rsp.status, rsp.item_value, rsp.last_of_run);
					fail_cnt++;
				end else begin
					check_rsp(expected_rsps.pop_front(), rsp);
					checked_cnt++;
				end
			end
			if (req_valid && req_ready) begin
				accepted_cnt++;
				predict_results(req);
			end
		end
	end

	// -------------------------------------------------------------------------
	// Watchdog
	// -------------------------------------------------------------------------
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	// -------------------------------------------------------------------------
	// Stimulus and end of run
	// -------------------------------------------------------------------------
	initial begin
		int        i;
		int        c;
		int        random_cnt;
		int        seg_left;
		int        push_pct;
		int        pick;
		gen_mode_t mode;

		random_cnt = 0;
		seg_left   = 0;
		mode       = GEN_MIX;

		// empty queue: both pops and a listing report empty
		queue_req(REQ_POP_FRONT, rand_value());
		queue_req(REQ_POP_BACK, rand_value());
		queue_req(REQ_LIST, rand_value());
		// unused codes, each with a live-looking value
		for (c = REQ_FIRST_UNUSED; c <= REQ_LAST_UNUSED; c++)
			queue_req(3'(c), $urandom());
		// extremes at both ends; front push from slot zero wraps the ring
		queue_req(REQ_PUSH_BACK, VALUE_MIN);
		queue_req(REQ_PUSH_FRONT, VALUE_MAX);
		queue_req(REQ_PUSH_BACK, '0);
		queue_req(REQ_PUSH_FRONT, '1);
		queue_req(REQ_LIST, '0);
		queue_req(REQ_POP_BACK, '0);
		queue_req(REQ_POP_FRONT, '0);
		queue_req(REQ_POP_FRONT, '0);
		queue_req(REQ_POP_BACK, '0);
		queue_req(REQ_LIST, '0);

		// fill past capacity, list the full queue, then drain past empty
		for (i = 0; i < DEPTH + 2; i++)
			queue_req(rand_push(), rand_value());
		queue_req(REQ_LIST, rand_value());
		for (i = 0; i < DEPTH + 2; i++)
			queue_req(rand_pop(), rand_value());

		// random runs, each leaning toward filling, draining or neither
		while (random_cnt < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				mode     = gen_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(8, 40);
			end
			case (mode)
				GEN_FILL:  push_pct = 85;
				GEN_DRAIN: push_pct = 15;
				default:   push_pct = 50;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// noise: dropped by the block, not counted toward the run
				queue_req(3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED)), $urandom());
			end else begin
				if (pick < 12)
					queue_req(REQ_LIST, rand_value());
				else if ($urandom_range(0, 99) < push_pct)
					queue_req(rand_push(), rand_value());
				else
					queue_req(rand_pop(), rand_value());
				random_cnt++;
				seg_left--;
			end
		end

		// hold reset, then release it on a rising edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item to be taken and every result to come back
		while (accepted_cnt != total_items || expected_rsps.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d requests taken (%0d with unused codes), %0d results checked",
			accepted_cnt, ignored_cnt, checked_cnt);
		$display("summary: %0d pushes refused as full, %0d empty results, %0d full listings",
			refused_cnt, empty_cnt, full_lists);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
